### rtl/core/spds_pkg.sv
// constants shared by the segment pair distance core
// no dependencies
`default_nettype none
package spds_pkg;
	localparam int COORD_BITS_DEF     = 16;
	localparam int DIST_FRAC_BITS_DEF = 8;
	localparam int DIST_WIDTH         = 41;
endpackage
`default_nettype wire

### rtl/core/segment_pair_distance_squared_core.sv
// segment to segment squared distance core, fully pipelined
// depends on spds_pkg
// One segment pair enters per clock and one result word leaves per clock
// while out_stall does not hold the output. Five stages of differences,
// products, case selection and squaring come first, then a restoring divider
// that gives one quotient bit per stage, then two stages of minimum selection,
// the last being the output register.
// When out_stall holds the output word, the whole pipeline holds and in_stall
// is raised in the same cycle. distance_squared carries DIST_FRAC_BITS
// fractional bits, truncated; it is zero whenever segments_cross is set.
`default_nettype none
module segment_pair_distance_squared_core #(
	parameter int COORD_BITS     = spds_pkg::COORD_BITS_DEF,
	parameter int DIST_FRAC_BITS = spds_pkg::DIST_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COORD_BITS-1:0]      first_start_x,
	input  logic signed [COORD_BITS-1:0]      first_start_y,
	input  logic signed [COORD_BITS-1:0]      first_end_x,
	input  logic signed [COORD_BITS-1:0]      first_end_y,
	input  logic signed [COORD_BITS-1:0]      second_start_x,
	input  logic signed [COORD_BITS-1:0]      second_start_y,
	input  logic signed [COORD_BITS-1:0]      second_end_x,
	input  logic signed [COORD_BITS-1:0]      second_end_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [spds_pkg::DIST_WIDTH-1:0]   distance_squared,
	output logic                              segments_cross
);
	import spds_pkg::*;

	localparam int DFW = COORD_BITS + 1;
	localparam int PW  = 2 * DFW + 1;
	localparam int LW  = 2 * COORD_BITS + 2;
	localparam int MW  = 2 * COORD_BITS + 2;
	localparam int HL  = MW / 2;
	localparam int HH  = MW - HL;
	localparam int QW  = 2 * COORD_BITS + 3 + DIST_FRAC_BITS;
	localparam int DW  = QW;
	localparam int NW  = 2 * MW + DIST_FRAC_BITS;

	typedef struct packed {
		logic          is_div;
		logic [DW-1:0] ep;
		logic [LW-1:0] rem;
		logic [QW-1:0] nrem;
		logic [QW-1:0] quot;
		logic [LW-1:0] den;
	} lane_t;

	function automatic logic signed [PW-1:0] cross2(input logic signed [DFW-1:0] ax,
			input logic signed [DFW-1:0] ay, input logic signed [DFW-1:0] bx,
			input logic signed [DFW-1:0] by);
		return PW'(ax) * PW'(by) - PW'(ay) * PW'(bx);
	endfunction

	function automatic logic signed [PW-1:0] dot2(input logic signed [DFW-1:0] ax,
			input logic signed [DFW-1:0] ay, input logic signed [DFW-1:0] bx,
			input logic signed [DFW-1:0] by);
		return PW'(ax) * PW'(bx) + PW'(ay) * PW'(by);
	endfunction

	function automatic logic in_span(input logic signed [PW-1:0] num,
			input logic signed [PW-1:0] den);
		if (den > 0)
			return (num >= 0) && (num <= den);
		return (num <= 0) && (num >= den);
	endfunction

	// one restoring step: one quotient bit
	function automatic lane_t div_step(input lane_t x);
		logic [LW:0] t;
		logic        ge;
		lane_t       y;
		y = x;
		t = {x.rem, x.nrem[QW-1]};
		ge = (t >= {1'b0, x.den});
		if (ge)
			t = t - {1'b0, x.den};
		y.rem = t[LW-1:0];
		y.nrem = {x.nrem[QW-2:0], 1'b0};
		y.quot = {x.quot[QW-2:0], ge};
		return y;
	endfunction

	function automatic logic [DW-1:0] min_d(input logic [DW-1:0] a, input logic [DW-1:0] b);
		return (b < a) ? b : a;
	endfunction

	logic en;
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1: coordinate differences
	logic v_s1;
	logic signed [DFW-1:0] d1x_s1, d1y_s1, d2x_s1, d2y_s1, wx_s1, wy_s1;
	logic signed [DFW-1:0] rx_s1 [4];
	logic signed [DFW-1:0] ry_s1 [4];
	logic signed [DFW-1:0] qx_s1 [4];
	logic signed [DFW-1:0] qy_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1x_s1 <= DFW'(first_end_x) - DFW'(first_start_x);
			d1y_s1 <= DFW'(first_end_y) - DFW'(first_start_y);
			d2x_s1 <= DFW'(second_end_x) - DFW'(second_start_x);
			d2y_s1 <= DFW'(second_end_y) - DFW'(second_start_y);
			wx_s1 <= DFW'(second_start_x) - DFW'(first_start_x);
			wy_s1 <= DFW'(second_start_y) - DFW'(first_start_y);
			// first start against second segment
			rx_s1[0] <= DFW'(first_start_x) - DFW'(second_start_x);
			ry_s1[0] <= DFW'(first_start_y) - DFW'(second_start_y);
			qx_s1[0] <= DFW'(first_start_x) - DFW'(second_end_x);
			qy_s1[0] <= DFW'(first_start_y) - DFW'(second_end_y);
			// first end against second segment
			rx_s1[1] <= DFW'(first_end_x) - DFW'(second_start_x);
			ry_s1[1] <= DFW'(first_end_y) - DFW'(second_start_y);
			qx_s1[1] <= DFW'(first_end_x) - DFW'(second_end_x);
			qy_s1[1] <= DFW'(first_end_y) - DFW'(second_end_y);
			// second start against first segment
			rx_s1[2] <= DFW'(second_start_x) - DFW'(first_start_x);
			ry_s1[2] <= DFW'(second_start_y) - DFW'(first_start_y);
			qx_s1[2] <= DFW'(second_start_x) - DFW'(first_end_x);
			qy_s1[2] <= DFW'(second_start_y) - DFW'(first_end_y);
			// second end against first segment
			rx_s1[3] <= DFW'(second_end_x) - DFW'(first_start_x);
			ry_s1[3] <= DFW'(second_end_y) - DFW'(first_start_y);
			qx_s1[3] <= DFW'(second_end_x) - DFW'(first_end_x);
			qy_s1[3] <= DFW'(second_end_y) - DFW'(first_end_y);
		end
	end

	// stage 2: products
	logic v_s2;
	logic signed [PW-1:0] den_s2, tn_s2, sn_s2;
	logic [LW-1:0] lena_s2, lenc_s2;
	logic signed [PW-1:0] dot_s2 [4];
	logic signed [PW-1:0] cr_s2 [4];
	logic [LW-1:0] e0_s2 [4];
	logic [LW-1:0] e1_s2 [4];
	logic signed [PW-1:0] la_c, lc_c;
	logic signed [PW-1:0] e0_c [4];
	logic signed [PW-1:0] e1_c [4];

	always_comb begin
		la_c = dot2(d1x_s1, d1y_s1, d1x_s1, d1y_s1);
		lc_c = dot2(d2x_s1, d2y_s1, d2x_s1, d2y_s1);
		for (int k = 0; k < 4; k++) begin
			e0_c[k] = dot2(rx_s1[k], ry_s1[k], rx_s1[k], ry_s1[k]);
			e1_c[k] = dot2(qx_s1[k], qy_s1[k], qx_s1[k], qy_s1[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2 <= cross2(d1x_s1, d1y_s1, d2x_s1, d2y_s1);
			tn_s2 <= cross2(wx_s1, wy_s1, d2x_s1, d2y_s1);
			sn_s2 <= cross2(wx_s1, wy_s1, d1x_s1, d1y_s1);
			lena_s2 <= la_c[LW-1:0];
			lenc_s2 <= lc_c[LW-1:0];
			for (int k = 0; k < 2; k++) begin
				dot_s2[k] <= dot2(rx_s1[k], ry_s1[k], d2x_s1, d2y_s1);
				cr_s2[k] <= cross2(rx_s1[k], ry_s1[k], d2x_s1, d2y_s1);
			end
			for (int k = 2; k < 4; k++) begin
				dot_s2[k] <= dot2(rx_s1[k], ry_s1[k], d1x_s1, d1y_s1);
				cr_s2[k] <= cross2(rx_s1[k], ry_s1[k], d1x_s1, d1y_s1);
			end
			for (int k = 0; k < 4; k++) begin
				e0_s2[k] <= e0_c[k][LW-1:0];
				e1_s2[k] <= e1_c[k][LW-1:0];
			end
		end
	end

	// stage 3: crossing test and choice of nearest feature
	logic v_s3, cross_s3;
	logic isdiv_s3 [4];
	logic [DW-1:0] ep_s3 [4];
	logic [MW-1:0] mag_s3 [4];
	logic [LW-1:0] len_s3 [4];
	logic [LW-1:0] len_c [4];
	logic isdiv_c [4];
	logic [DW-1:0] ep_c [4];
	logic signed [PW-1:0] mag_c [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			len_c[k] = (k < 2) ? lenc_s2 : lena_s2;
			isdiv_c[k] = 1'b0;
			ep_c[k] = DW'(e0_s2[k]) << DIST_FRAC_BITS;
			mag_c[k] = cr_s2[k][PW-1] ? -cr_s2[k] : cr_s2[k];
			if (len_c[k] != '0 && !dot_s2[k][PW-1]) begin
				if (dot_s2[k] > $signed({1'b0, len_c[k]}))
					ep_c[k] = DW'(e1_s2[k]) << DIST_FRAC_BITS;
				else
					isdiv_c[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_s3 <= (den_s2 != '0) && in_span(tn_s2, den_s2) && in_span(sn_s2, den_s2);
			for (int k = 0; k < 4; k++) begin
				isdiv_s3[k] <= isdiv_c[k];
				ep_s3[k] <= ep_c[k];
				mag_s3[k] <= mag_c[k][MW-1:0];
				len_s3[k] <= len_c[k];
			end
		end
	end

	// stage 4: cross product squared as three partial products
	logic v_s4, cross_s4;
	logic isdiv_s4 [4];
	logic [DW-1:0] ep_s4 [4];
	logic [LW-1:0] len_s4 [4];
	logic [2*HH-1:0] ph_s4 [4];
	logic [HH+HL-1:0] pm_s4 [4];
	logic [2*HL-1:0] pl_s4 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_s4 <= cross_s3;
			for (int k = 0; k < 4; k++) begin
				isdiv_s4[k] <= isdiv_s3[k];
				ep_s4[k] <= ep_s3[k];
				len_s4[k] <= len_s3[k];
				ph_s4[k] <= (2*HH)'(mag_s3[k][MW-1:HL]) * (2*HH)'(mag_s3[k][MW-1:HL]);
				pm_s4[k] <= (HH+HL)'(mag_s3[k][MW-1:HL]) * (HH+HL)'(mag_s3[k][HL-1:0]);
				pl_s4[k] <= (2*HL)'(mag_s3[k][HL-1:0]) * (2*HL)'(mag_s3[k][HL-1:0]);
			end
		end
	end

	// stage 5 is divider entry, then one stage per quotient bit
	logic  vdiv_s [0:QW];
	logic  crdiv_s [0:QW];
	lane_t [3:0] lane_div_s [0:QW];
	lane_t [3:0] entry_c;
	logic [NW-1:0] num_c [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			num_c[k] = (NW'(ph_s4[k]) << (2*HL)) + (NW'(pm_s4[k]) << (HL+1)) + NW'(pl_s4[k]);
			num_c[k] = num_c[k] << DIST_FRAC_BITS;
			entry_c[k].is_div = isdiv_s4[k];
			entry_c[k].ep = ep_s4[k];
			// quotient fits in QW bits, so the top part is already below the divisor
			entry_c[k].rem = LW'(num_c[k] >> QW);
			entry_c[k].nrem = num_c[k][QW-1:0];
			entry_c[k].quot = '0;
			entry_c[k].den = len_s4[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vdiv_s[0] <= 1'b0;
		else if (en)
			vdiv_s[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crdiv_s[0] <= cross_s4;
			lane_div_s[0] <= entry_c;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vdiv_s[j] <= 1'b0;
			else if (en)
				vdiv_s[j] <= vdiv_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				crdiv_s[j] <= crdiv_s[j-1];
				for (int k = 0; k < 4; k++)
					lane_div_s[j][k] <= div_step(lane_div_s[j-1][k]);
			end
		end
	end

	// minimum over the four candidates
	logic [DW-1:0] dist_c [4];
	logic v_m_s, cross_m_s;
	logic [DW-1:0] m01_m_s, m23_m_s;
	logic [DW-1:0] best_c;

	always_comb begin
		for (int k = 0; k < 4; k++)
			dist_c[k] = lane_div_s[QW][k].is_div ? lane_div_s[QW][k].quot : lane_div_s[QW][k].ep;
		best_c = min_d(m01_m_s, m23_m_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m_s <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_m_s <= vdiv_s[QW];
			out_valid <= v_m_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_m_s <= crdiv_s[QW];
			m01_m_s <= min_d(dist_c[0], dist_c[1]);
			m23_m_s <= min_d(dist_c[2], dist_c[3]);
			segments_cross <= cross_m_s;
			distance_squared <= cross_m_s ? '0 : DIST_WIDTH'(best_c);
		end
	end

	a_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && segments_cross |-> distance_squared == '0)
		else $error("crossing word with nonzero distance");

	a_div_entry_fits: assert property (@(posedge clk) disable iff (!arst_n)
		vdiv_s[0] && lane_div_s[0][0].is_div |-> lane_div_s[0][0].rem < lane_div_s[0][0].den)
		else $error("divider entry remainder not below divisor");

	a_div_exit_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vdiv_s[QW] && lane_div_s[QW][3].is_div |-> lane_div_s[QW][3].rem < lane_div_s[QW][3].den)
		else $error("divider remainder out of range");

	a_out_from_min: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_m_s))
		else $error("output word without a source");

endmodule
`default_nettype wire

### tb/tb_segment_pair_distance_squared_core.sv
// self-checking testbench for the segment pair squared distance core
// depends on spds_pkg and segment_pair_distance_squared_core
`timescale 1ns / 100ps
`default_nettype none
module tb_segment_pair_distance_squared_core;
	import spds_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int FB = DIST_FRAC_BITS_DEF;
	localparam int TAIL_CYCLES = 2 * CB + FB + 30;

	typedef struct {
		logic signed [CB-1:0] ax, ay, bx, by, cx, cy, ex, ey;
	} seg_pair_t;

	typedef struct {
		logic [DIST_WIDTH-1:0] dsq;
		logic                  crossed;
	} dist_word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [CB-1:0] first_start_x, first_start_y, first_end_x, first_end_y;
	logic signed [CB-1:0] second_start_x, second_start_y, second_end_x, second_end_y;
	logic [DIST_WIDTH-1:0] distance_squared;
	logic segments_cross;

	seg_pair_t  pair_q[$];
	dist_word_t dist_q[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;
	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int crossings = 0;

	segment_pair_distance_squared_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.first_start_x(first_start_x), .first_start_y(first_start_y),
		.first_end_x(first_end_x), .first_end_y(first_end_y),
		.second_start_x(second_start_x), .second_start_y(second_start_y),
		.second_end_x(second_end_x), .second_end_y(second_end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance_squared(distance_squared), .segments_cross(segments_cross)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [127:0] endpoint_dist(longint px, longint py, longint qx, longint qy);
		longint dx, dy;
		dx = qx - px;
		dy = qy - py;
		return 128'(dx * dx + dy * dy) << FB;
	endfunction

	function automatic logic [127:0] point_to_segment(longint px, longint py, longint ax,
			longint ay, longint bx, longint by);
		longint dx, dy, rx, ry, len2, dot, cr;
		logic [127:0] num;
		dx = bx - ax;
		dy = by - ay;
		rx = px - ax;
		ry = py - ay;
		if (dx == 0 && dy == 0) return endpoint_dist(px, py, ax, ay);
		len2 = dx * dx + dy * dy;
		dot = rx * dx + ry * dy;
		if (dot < 0) return endpoint_dist(px, py, ax, ay);
		if (dot > len2) return endpoint_dist(px, py, bx, by);
		cr = rx * dy - ry * dx;
		if (cr < 0) cr = -cr;
		num = (128'(cr) * 128'(cr)) << FB;
		return num / 128'(len2);
	endfunction

	function automatic bit within_span(longint num, longint den);
		if (den > 0) return num >= 0 && num <= den;
		return num <= 0 && num >= den;
	endfunction

	function automatic dist_word_t predict_distance(seg_pair_t p);
		longint ax, ay, bx, by, cx, cy, ex, ey, den, tn, sn;
		logic [127:0] best, t;
		dist_word_t r;
		ax = longint'(p.ax); ay = longint'(p.ay);
		bx = longint'(p.bx); by = longint'(p.by);
		cx = longint'(p.cx); cy = longint'(p.cy);
		ex = longint'(p.ex); ey = longint'(p.ey);
		den = (bx - ax) * (ey - cy) - (by - ay) * (ex - cx);
		r.crossed = 1'b0;
		if (den != 0) begin
			tn = (cx - ax) * (ey - cy) - (cy - ay) * (ex - cx);
			sn = (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
			r.crossed = within_span(tn, den) && within_span(sn, den);
		end
		if (r.crossed) begin
			best = '0;
		end else begin
			best = point_to_segment(ax, ay, cx, cy, ex, ey);
			t = point_to_segment(bx, by, cx, cy, ex, ey);
			if (t < best) best = t;
			t = point_to_segment(cx, cy, ax, ay, bx, by);
			if (t < best) best = t;
			t = point_to_segment(ex, ey, ax, ay, bx, by);
			if (t < best) best = t;
		end
		r.dsq = best[DIST_WIDTH-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch on word %0d: %s got %0d expected %0d", words_out, what, got, want);
	endtask

	// driver: take a new pair only when the current word has gone or none is held
	always @(posedge clk or negedge arst_n) begin
		seg_pair_t p;
		if (!arst_n) begin
			in_valid <= 0;
			{first_start_x, first_start_y, first_end_x, first_end_y} <= '0;
			{second_start_x, second_start_y, second_end_x, second_end_y} <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				p.ax = first_start_x; p.ay = first_start_y;
				p.bx = first_end_x; p.by = first_end_y;
				p.cx = second_start_x; p.cy = second_start_y;
				p.ex = second_end_x; p.ey = second_end_y;
				dist_q.push_back(predict_distance(p));
				words_in++;
			end
			if (!in_valid || !in_stall) begin
				if (pair_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					p = pair_q.pop_front();
					first_start_x <= p.ax; first_start_y <= p.ay;
					first_end_x <= p.bx; first_end_y <= p.by;
					second_start_x <= p.cx; second_start_y <= p.cy;
					second_end_x <= p.ex; second_end_y <= p.ey;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver stall, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else if (hold_asked != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= 400;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		dist_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (dist_q.size() == 0) begin
				report_mismatch("unexpected word", 64'(distance_squared), 64'(0));
			end else begin
				w = dist_q.pop_front();
				if (distance_squared !== w.dsq)
					report_mismatch("distance_squared", 64'(distance_squared), 64'(w.dsq));
				if (segments_cross !== w.crossed)
					report_mismatch("segments_cross", 64'(segments_cross), 64'(w.crossed));
				if (w.crossed) crossings++;
			end
			words_out++;
		end
	end

	task automatic add_pair(int ax, int ay, int bx, int by, int cx, int cy, int ex, int ey);
		seg_pair_t p;
		p.ax = CB'(ax); p.ay = CB'(ay); p.bx = CB'(bx); p.by = CB'(by);
		p.cx = CB'(cx); p.cy = CB'(cy); p.ex = CB'(ex); p.ey = CB'(ey);
		pair_q.push_back(p);
	endtask

	function automatic int rnd_coord(int span);
		if (span == 0) return int'($urandom_range(65535)) - 32768;
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// mostly random pairs; some nearby, degenerate, parallel or end-touching
	task automatic add_random(int n);
		int k, span, ax, ay, bx, by, cx, cy, ex, ey, ox, oy;
		for (int i = 0; i < n; i++) begin
			k = int'($urandom_range(5));
			span = (k == 0) ? 0 : ($urandom_range(1) ? 60 : 8000);
			ox = (span == 0) ? 0 : rnd_coord(20000);
			oy = (span == 0) ? 0 : rnd_coord(20000);
			ax = ox + rnd_coord(span); ay = oy + rnd_coord(span);
			bx = ox + rnd_coord(span); by = oy + rnd_coord(span);
			cx = ox + rnd_coord(span); cy = oy + rnd_coord(span);
			ex = ox + rnd_coord(span); ey = oy + rnd_coord(span);
			case (k)
				2: begin ex = cx; ey = cy; end
				3: begin cx = ax + 7; cy = ay - 3; ex = bx + 7; ey = by - 3; end
				4: begin cx = bx; cy = by; end
				default: ;
			endcase
			add_pair(ax, ay, bx, by, cx, cy, ex, ey);
		end
	endtask

	task automatic drain();
		do @(negedge clk); while (pair_q.size() != 0 || in_valid || dist_q.size() != 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: extremes, degenerate, crossing, parallel, projection cases
		add_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
		add_pair(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768);
		add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		add_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
		add_pair(-32768, -32768, -32767, 32767, 32767, -32768, 32766, 32767);
		add_pair(0, 0, 10, 0, 5, 3, 5, 3);
		add_pair(0, 0, 0, 0, 0, 0, 0, 0);
		add_pair(0, 0, 10, 10, 0, 10, 10, 0);
		add_pair(0, 0, 10, 0, 10, 0, 20, 5);
		add_pair(0, 0, 10, 0, 0, 1, 10, 1);
		add_pair(0, 0, 10, 0, 5, 0, 20, 0);
		add_pair(0, 0, 10, 0, 12, 0, 20, 0);
		add_pair(0, 0, 10, 0, -5, 3, -4, 9);
		add_pair(0, 0, 10, 0, 15, 3, 17, 9);
		add_pair(0, 0, 7, 3, 2, 5, 9, 11);
		add_pair(0, 0, 10, 0, 5, 1, 5, 8);
		add_pair(0, 0, 10, 0, 5, 0, 5, 8);
		add_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
		add_pair(-1, -1, -1, -1, -1, -1, 0, 0);
		add_pair(32767, -32768, -32768, 32767, 0, 0, 3, 1);
		// back-pressure: the receiver holds off while pairs keep coming
		hold_asked = 1;
		add_random(200);
		drain();

		idle_pct = 84; stall_pct = 0;
		add_random(170);
		drain();
		idle_pct = 0; stall_pct = 84;
		add_random(170);
		drain();
		idle_pct = 21; stall_pct = 21;
		add_random(170);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d segment pairs, %0d results, %0d crossing, under four idle mixes",
			words_in, words_out, crossings);
		if (errors == 0 && dist_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
